[sv/df3d_pkg.sv]
// Shared types and constants of the 3D distance field block.
// Holds command codes, register indexes, field widths and the neighbour table.
// No dependencies.
`default_nettype none

package df3d_pkg;

    // Field widths of the command, response and register interfaces.
    localparam int OPC_W    = 2;
    localparam int COORD_W  = 5;
    localparam int VALUE_W  = 16;
    localparam int DIST_W   = 6;
    localparam int PASS_W   = 16;
    localparam int SIZE_W   = 6;
    localparam int THRESH_W = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Largest distance the store can hold; maxd saturates here.
    localparam logic [DIST_W-1:0] DIST_CAP = '1;

    // Per-voxel relaxation sequence: step 0 reads the voxel itself, steps 1..14
    // read the neighbours, the last step writes back.
    localparam int NB_COUNT = 14;
    localparam int STEP_W   = 4;
    localparam logic [STEP_W-1:0] STEP_OWN  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DATA = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NB_COUNT + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_SIZE_X    = 2'd0,
        REG_SIZE_Y    = 2'd1,
        REG_SIZE_Z    = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

    // Offset along one axis: minus one, zero or plus one.
    typedef enum logic [1:0] {
        NB_ZERO = 2'b00,
        NB_POS  = 2'b01,
        NB_NEG  = 2'b11
    } nb_dir_t;

    typedef struct packed {
        nb_dir_t dx;
        nb_dir_t dy;
        nb_dir_t dz;
    } nb_off_t;

    // The 14-neighbourhood: six faces first, then the eight corners.
    function automatic nb_off_t nb_offset(input logic [STEP_W-1:0] idx);
        nb_off_t off;
        case (idx)
            4'd0:    off = '{NB_NEG,  NB_ZERO, NB_ZERO};
            4'd1:    off = '{NB_POS,  NB_ZERO, NB_ZERO};
            4'd2:    off = '{NB_ZERO, NB_NEG,  NB_ZERO};
            4'd3:    off = '{NB_ZERO, NB_POS,  NB_ZERO};
            4'd4:    off = '{NB_ZERO, NB_ZERO, NB_NEG};
            4'd5:    off = '{NB_ZERO, NB_ZERO, NB_POS};
            4'd6:    off = '{NB_NEG,  NB_NEG,  NB_NEG};
            4'd7:    off = '{NB_NEG,  NB_POS,  NB_NEG};
            4'd8:    off = '{NB_POS,  NB_POS,  NB_NEG};
            4'd9:    off = '{NB_POS,  NB_NEG,  NB_NEG};
            4'd10:   off = '{NB_NEG,  NB_NEG,  NB_POS};
            4'd11:   off = '{NB_NEG,  NB_POS,  NB_POS};
            4'd12:   off = '{NB_POS,  NB_POS,  NB_POS};
            4'd13:   off = '{NB_POS,  NB_NEG,  NB_POS};
            default: off = '{NB_ZERO, NB_ZERO, NB_ZERO};
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

[sv/df3d_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Read during a write to the same address returns the old data.
// No dependencies.
`default_nettype none

module df3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/distance_field_3d_14_neighbour.sv]
// Top level of the 3D distance field block with 14-neighbour relaxation.
// Depends on df3d_pkg (types, constants, neighbour table) and df3d_ram.
//
// Usage
// -----
// Commands arrive on the cmd channel (cmd_valid/cmd_ready) and every accepted
// command transaction produces exactly one response transaction on the rsp
// channel (rsp_valid/rsp_ready) carrying distance and pass_count. A load
// classifies one voxel as empty or occupied against the threshold, a compute
// fills the distance store and relaxes it to a fixed point, and a read returns
// the stored distance of one voxel. Grid extents and the threshold are set
// through the APB port and must only change while the block is idle.
//
// Sequencing: the block works on one command at a time and takes the next one
// when it is back in its idle state, which it enters as its result enters the
// response register. A load or an unused opcode goes from acceptance straight
// to S_DONE, and a read passes through S_READ first for the registered distance
// memory read. A compute first initializes the voxels of the grid in S_INIT
// and S_INIT_END, then relaxes them pass by pass, skipping an occupied voxel
// after its own read, and hands over the result through S_DONE. The pass cost
// is set by the single read port of the distance memory, which serves the
// voxel and its 14 neighbours in turn.
//
// Reset clears the control state and loads the registers with their defaults
// (extents 32, threshold 0). The voxel memories are not cleared; voxels must be
// loaded before a compute and computed before they are read. If the receiver
// stalls, the response waits in the output register while the next command is
// accepted and executed; its result then waits until the output register frees.
`default_nettype none

module distance_field_3d_14_neighbour #(
    parameter int MAX_DIM     = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Command channel.
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic [df3d_pkg::OPC_W-1:0]        opcode,
    input  wire logic [df3d_pkg::COORD_W-1:0]      coord_x,
    input  wire logic [df3d_pkg::COORD_W-1:0]      coord_y,
    input  wire logic [df3d_pkg::COORD_W-1:0]      coord_z,
    input  wire logic [df3d_pkg::VALUE_W-1:0]      voxel_value,

    // Response channel.
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic      [df3d_pkg::DIST_W-1:0]       distance,
    output logic      [df3d_pkg::PASS_W-1:0]       pass_count,

    // Register port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [df3d_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [df3d_pkg::PDATA_W-1:0]      pwdata,
    output logic      [df3d_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    import df3d_pkg::*;

    // Coordinate width inside the memories, extent width, address width.
    localparam int CW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int XW    = (DW > COORD_W) ? DW : COORD_W;
    localparam int CMP_W = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int EW    = 7;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_READ     = 6'b000010,
        S_INIT     = 6'b000100,
        S_INIT_END = 6'b001000,
        S_RELAX    = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]   size_x_reg;
    logic [SIZE_W-1:0]   size_y_reg;
    logic [SIZE_W-1:0]   size_z_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic                cfg_write;
    reg_idx_t            cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= SIZE_W'(32);
            size_y_reg    <= SIZE_W'(32);
            size_z_reg    <= SIZE_W'(32);
            threshold_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_SIZE_X:    size_x_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg    <= pwdata[SIZE_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SIZE_X:    prdata = PDATA_W'(size_x_reg);
            REG_SIZE_Y:    prdata = PDATA_W'(size_y_reg);
            REG_SIZE_Z:    prdata = PDATA_W'(size_z_reg);
            REG_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    // Effective extents: zero acts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [EW-1:0] s7;
        s7 = EW'(s);
        if (s7 == '0)
        begin
            return DW'(1);
        end
        else if (s7 > EW'(MAX_DIM))
        begin
            return DW'(MAX_DIM);
        end
        return DW'(s7);
    endfunction

    logic [DW-1:0]     nx, ny, nz, nmax;
    logic [EW-1:0]     nmax7;
    logic [DIST_W-1:0] maxd;

    assign nx    = eff_size(size_x_reg);
    assign ny    = eff_size(size_y_reg);
    assign nz    = eff_size(size_z_reg);
    assign nmax  = (nx >= ny) ? ((nx >= nz) ? nx : nz) : ((ny >= nz) ? ny : nz);
    assign nmax7 = EW'(nmax);
    assign maxd  = (nmax7 > EW'(DIST_CAP)) ? DIST_CAP : nmax7[DIST_W-1:0];

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    logic          cmd_inside;
    logic [AW-1:0] cmd_addr;
    logic          cmd_empty;

    assign cmd_inside = (XW'(coord_x) < XW'(nx)) && (XW'(coord_y) < XW'(ny)) &&
                        (XW'(coord_z) < XW'(nz));
    assign cmd_addr   = {CW'(coord_z), CW'(coord_y), CW'(coord_x)};
    assign cmd_empty  = voxel_value[CMP_W-1:0] <= threshold_reg[CMP_W-1:0];

    // ------------------------------------------------------------------
    // Sweep counters and neighbour addressing
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CW-1:0]     x_reg, y_reg, z_reg;
    logic [CW-1:0]     x_next, y_next, z_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_x, last_y, last_z, last_voxel;
    logic [CW-1:0]     x_adv, y_adv, z_adv;
    logic [AW-1:0]     cur_addr;

    assign last_x     = x_reg == CW'(nx - DW'(1));
    assign last_y     = y_reg == CW'(ny - DW'(1));
    assign last_z     = z_reg == CW'(nz - DW'(1));
    assign last_voxel = last_x && last_y && last_z;
    assign x_adv      = last_x ? '0 : x_reg + CW'(1);
    assign y_adv      = last_x ? (last_y ? '0 : y_reg + CW'(1)) : y_reg;
    assign z_adv      = (last_x && last_y) ? (last_z ? '0 : z_reg + CW'(1)) : z_reg;
    assign cur_addr   = {z_reg, y_reg, x_reg};

    nb_off_t       nb_off;
    logic [CW-1:0] nb_x, nb_y, nb_z;
    logic          nb_ok_x, nb_ok_y, nb_ok_z, nb_in_grid;
    logic [AW-1:0] nb_addr;

    assign nb_off = nb_offset(step_reg - STEP_W'(1));

    always_comb
    begin
        case (nb_off.dx)
            NB_NEG:  begin nb_x = x_reg - CW'(1); nb_ok_x = x_reg != '0; end
            NB_POS:  begin nb_x = x_reg + CW'(1); nb_ok_x = !last_x;     end
            default: begin nb_x = x_reg;          nb_ok_x = 1'b1;        end
        endcase
        case (nb_off.dy)
            NB_NEG:  begin nb_y = y_reg - CW'(1); nb_ok_y = y_reg != '0; end
            NB_POS:  begin nb_y = y_reg + CW'(1); nb_ok_y = !last_y;     end
            default: begin nb_y = y_reg;          nb_ok_y = 1'b1;        end
        endcase
        case (nb_off.dz)
            NB_NEG:  begin nb_z = z_reg - CW'(1); nb_ok_z = z_reg != '0; end
            NB_POS:  begin nb_z = z_reg + CW'(1); nb_ok_z = !last_z;     end
            default: begin nb_z = z_reg;          nb_ok_z = 1'b1;        end
        endcase
    end

    assign nb_in_grid = nb_ok_x && nb_ok_y && nb_ok_z;
    assign nb_addr    = {nb_z, nb_y, nb_x};

    // ------------------------------------------------------------------
    // Memories: one bit per voxel for the empty map, six for the distance.
    // ------------------------------------------------------------------
    logic              e_we;
    logic              e_rdata;
    logic              d_we;
    logic [AW-1:0]     d_waddr;
    logic [DIST_W-1:0] d_wdata;
    logic [AW-1:0]     d_raddr;
    logic [DIST_W-1:0] d_rdata;

    df3d_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_empty_map (
        .clk   (clk),
        .we    (e_we),
        .waddr (cmd_addr),
        .wdata (cmd_empty),
        .raddr (cur_addr),
        .rdata (e_rdata)
    );

    df3d_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_distance_store (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic              init_wr_valid_reg, init_wr_valid_next;
    logic [AW-1:0]     init_addr_reg, init_addr_next;
    logic              nb_ok_reg, nb_ok_next;
    logic              changed_reg, changed_next;
    logic              rd_inside_reg, rd_inside_next;
    logic [DIST_W-1:0] own_reg, own_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [PASS_W-1:0] pass_inc;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] dist_out_reg, dist_out_next;
    logic [PASS_W-1:0] pass_out_reg, pass_out_next;
    logic [DIST_W:0]   cand;
    logic              relax_we;
    logic              voxel_changed;
    logic              advance;

    assign cmd_ready  = state_reg == S_IDLE;
    assign rsp_valid  = out_valid_reg;
    assign distance   = dist_out_reg;
    assign pass_count = pass_out_reg;

    assign pass_inc = (pass_reg == '1) ? pass_reg : pass_reg + PASS_W'(1);
    assign cand     = {1'b0, d_rdata} + (DIST_W + 1)'(1);

    always_comb
    begin
        state_next         = state_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        z_next             = z_reg;
        step_next          = step_reg;
        init_wr_valid_next = init_wr_valid_reg;
        init_addr_next     = init_addr_reg;
        nb_ok_next         = nb_ok_reg;
        changed_next       = changed_reg;
        rd_inside_next     = rd_inside_reg;
        own_next           = own_reg;
        best_next          = best_reg;
        res_dist_next      = res_dist_reg;
        pass_next          = pass_reg;
        out_valid_next     = out_valid_reg && !rsp_ready;
        dist_out_next      = dist_out_reg;
        pass_out_next      = pass_out_reg;
        e_we               = 1'b0;
        relax_we           = 1'b0;
        voxel_changed      = 1'b0;
        advance            = 1'b0;

        // The initialization write follows its empty map read in the next cycle.
        d_we    = init_wr_valid_reg;
        d_waddr = init_addr_reg;
        d_wdata = e_rdata ? maxd : '0;
        d_raddr = cmd_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_dist_next = '0;
                    pass_next     = '0;
                    unique case (opcode_t'(opcode))
                        OP_LOAD:
                        begin
                            e_we       = cmd_inside;
                            state_next = S_DONE;
                        end
                        OP_COMPUTE:
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            z_next     = '0;
                            state_next = S_INIT;
                        end
                        OP_READ:
                        begin
                            rd_inside_next = cmd_inside;
                            state_next     = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_dist_next = rd_inside_reg ? d_rdata : '0;
                state_next    = S_DONE;
            end

            S_INIT:
            begin
                init_wr_valid_next = 1'b1;
                init_addr_next     = cur_addr;
                x_next             = x_adv;
                y_next             = y_adv;
                z_next             = z_adv;
                if (last_voxel)
                begin
                    state_next = S_INIT_END;
                end
            end

            S_INIT_END:
            begin
                init_wr_valid_next = 1'b0;
                step_next          = STEP_OWN;
                changed_next       = 1'b0;
                pass_next          = '0;
                state_next         = S_RELAX;
            end

            S_RELAX:
            begin
                d_raddr    = (step_reg == STEP_OWN) ? cur_addr : nb_addr;
                nb_ok_next = nb_in_grid;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_DATA)
                begin
                    // Own distance and empty bit arrive; occupied voxels stay at 0.
                    own_next  = d_rdata;
                    best_next = d_rdata;
                    advance   = !e_rdata;
                end
                else if (step_reg != STEP_OWN)
                begin
                    if (nb_ok_reg && (cand < {1'b0, best_reg}))
                    begin
                        best_next = cand[DIST_W-1:0];
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        advance = 1'b1;
                        if (best_next < own_reg)
                        begin
                            relax_we      = 1'b1;
                            voxel_changed = 1'b1;
                            d_we          = 1'b1;
                            d_waddr       = cur_addr;
                            d_wdata       = best_next;
                        end
                    end
                end
                if (advance)
                begin
                    step_next    = STEP_OWN;
                    x_next       = x_adv;
                    y_next       = y_adv;
                    z_next       = z_adv;
                    changed_next = changed_reg || voxel_changed;
                    if (last_voxel)
                    begin
                        pass_next    = pass_inc;
                        changed_next = 1'b0;
                        if (!(changed_reg || voxel_changed))
                        begin
                            res_dist_next = '0;
                            state_next    = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    dist_out_next  = res_dist_reg;
                    pass_out_next  = pass_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            x_reg             <= '0;
            y_reg             <= '0;
            z_reg             <= '0;
            step_reg          <= STEP_OWN;
            init_wr_valid_reg <= 1'b0;
            nb_ok_reg         <= 1'b0;
            changed_reg       <= 1'b0;
            pass_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            x_reg             <= x_next;
            y_reg             <= y_next;
            z_reg             <= z_next;
            step_reg          <= step_next;
            init_wr_valid_reg <= init_wr_valid_next;
            nb_ok_reg         <= nb_ok_next;
            changed_reg       <= changed_next;
            pass_reg          <= pass_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        init_addr_reg <= init_addr_next;
        rd_inside_reg <= rd_inside_next;
        own_reg       <= own_next;
        best_reg      <= best_next;
        res_dist_reg  <= res_dist_next;
        dist_out_reg  <= dist_out_next;
        pass_out_reg  <= pass_out_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The trailing initialization write never collides with a relaxation write.
    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(init_wr_valid_reg && relax_we))
        else $error("initialization and relaxation write the distance store together");

    // Relaxation only ever lowers a distance.
    a_relax_lowers: assert property (@(posedge clk) disable iff (!rst_n)
        relax_we |-> (d_wdata < own_reg))
        else $error("relaxation write does not lower the distance");

    // The last initialization write has drained before the first pass reads.
    a_init_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RELAX) |-> !init_wr_valid_reg)
        else $error("initialization write still pending during relaxation");

    // The sweep counters stay inside the grid while sweeping.
    a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_INIT) || (state_reg == S_RELAX)) |->
        ((XW'(x_reg) < XW'(nx)) && (XW'(y_reg) < XW'(ny)) && (XW'(z_reg) < XW'(nz))))
        else $error("sweep counter outside the grid");

endmodule

`default_nettype wire

[sim/distance_field_checker.sv]
`timescale 1ns / 1ps
// Response checker for the 3D distance field block: it mirrors the registers and
// both voxel memories, predicts every response and compares it field by field.
// Depends on df3d_pkg for field widths, command codes and register indexes.
module distance_field_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  logic                            cmd_ready,
    input  logic [df3d_pkg::OPC_W-1:0]      opcode,
    input  logic [df3d_pkg::COORD_W-1:0]    coord_x,
    input  logic [df3d_pkg::COORD_W-1:0]    coord_y,
    input  logic [df3d_pkg::COORD_W-1:0]    coord_z,
    input  logic [df3d_pkg::VALUE_W-1:0]    voxel_value,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [df3d_pkg::DIST_W-1:0]     distance,
    input  logic [df3d_pkg::PASS_W-1:0]     pass_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [df3d_pkg::PADDR_W-1:0]    paddr,
    input  logic [df3d_pkg::PDATA_W-1:0]    pwdata,
    output int                              fail_count,
    output int                              pending
);
    import df3d_pkg::*;

    localparam int GRID     = 32;
    localparam int CELLS    = GRID * GRID * GRID;
    localparam int PASS_MAX = 65535;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic [PASS_W-1:0] passes;
    } answer_t;

    answer_t              answers_due[$];
    logic [SIZE_W-1:0]    span_x    = SIZE_W'(GRID);
    logic [SIZE_W-1:0]    span_y    = SIZE_W'(GRID);
    logic [SIZE_W-1:0]    span_z    = SIZE_W'(GRID);
    logic [THRESH_W-1:0]  threshold = '0;
    bit                   is_empty  [CELLS];
    logic [DIST_W-1:0]    dist_mem  [CELLS];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // A size of zero behaves as one, anything beyond the grid as the full grid.
    function automatic int extent(logic [SIZE_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > GRID)
            return GRID;
        return int'(raw);
    endfunction

    function automatic int cell_of(int x, int y, int z);
        return x + GRID * (y + GRID * z);
    endfunction

    // Seeds the grid, then sweeps it in place (x fastest) until a sweep changes
    // nothing. Returns the sweep count including that last quiet sweep.
    function automatic logic [PASS_W-1:0] relax_grid();
        int  nx, ny, nz, far, passes, c, vx, vy, vz, cand, faces;
        bit  changed;
        nx  = extent(span_x);
        ny  = extent(span_y);
        nz  = extent(span_z);
        far = nx;
        if (ny > far)
            far = ny;
        if (nz > far)
            far = nz;
        if (far > int'(DIST_CAP))
            far = int'(DIST_CAP);
        for (int z = 0; z < nz; z++)
            for (int y = 0; y < ny; y++)
                for (int x = 0; x < nx; x++)
                begin
                    c = cell_of(x, y, z);
                    dist_mem[c] = is_empty[c] ? DIST_W'(far) : '0;
                end
        passes = 0;
        do
        begin
            changed = 1'b0;
            for (int z = 0; z < nz; z++)
                for (int y = 0; y < ny; y++)
                    for (int x = 0; x < nx; x++)
                    begin
                        c = cell_of(x, y, z);
                        if (is_empty[c])
                        begin
                            // Six faces and eight corners: one or three axes move.
                            for (int dz = -1; dz <= 1; dz++)
                                for (int dy = -1; dy <= 1; dy++)
                                    for (int dx = -1; dx <= 1; dx++)
                                    begin
                                        faces = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
                                        if (faces == 1 || faces == 3)
                                        begin
                                            vx = x + dx;
                                            vy = y + dy;
                                            vz = z + dz;
                                            if (vx < 0 || vy < 0 || vz < 0 ||
                                                vx >= nx || vy >= ny || vz >= nz)
                                                cand = far;
                                            else
                                                cand = int'(dist_mem[cell_of(vx, vy, vz)]) + 1;
                                            if (cand < int'(dist_mem[c]))
                                            begin
                                                dist_mem[c] = DIST_W'(cand);
                                                changed     = 1'b1;
                                            end
                                        end
                                    end
                        end
                    end
            if (passes < PASS_MAX)
                passes++;
        end
        while (changed);
        return PASS_W'(passes);
    endfunction

    function automatic answer_t apply_command(opcode_t op, logic [COORD_W-1:0] x,
                                              logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                              logic [VALUE_W-1:0] value);
        answer_t ans;
        bit      in_range;
        int      c;
        ans      = '0;
        in_range = int'(x) < extent(span_x) && int'(y) < extent(span_y) &&
                   int'(z) < extent(span_z);
        c        = cell_of(int'(x), int'(y), int'(z));
        case (op)
            OP_LOAD:    if (in_range) is_empty[c] = (value <= threshold);
            OP_COMPUTE: ans.passes = relax_grid();
            OP_READ:    if (in_range) ans.dist_val = dist_mem[c];
            default:    ;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin : monitor
        answer_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_SIZE_X:    span_x    = pwdata[SIZE_W-1:0];
                    REG_SIZE_Y:    span_y    = pwdata[SIZE_W-1:0];
                    REG_SIZE_Z:    span_z    = pwdata[SIZE_W-1:0];
                    REG_THRESHOLD: threshold = pwdata[THRESH_W-1:0];
                    default:       ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected response transaction: distance %0d, pass_count %0d",
                           distance, pass_count);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (distance !== want.dist_val)
                    begin
                        $error("distance: expected %0d, actual %0d", want.dist_val, distance);
                        fail_count++;
                    end
                    if (pass_count !== want.passes)
                    begin
                        $error("pass_count: expected %0d, actual %0d", want.passes, pass_count);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                answers_due.push_back(apply_command(opcode_t'(opcode), coord_x, coord_y,
                                                    coord_z, voxel_value));
            pending = answers_due.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the 3D distance field testbench: clock, reset, command and register
// stimulus, response back-pressure and the verdict. Depends on df3d_pkg, the
// block distance_field_3d_14_neighbour and distance_field_checker.
module testbench;
    import df3d_pkg::*;

    localparam int GRID          = 32;
    localparam int CELLS         = GRID * GRID * GRID;
    localparam int PHASES        = 8;
    localparam int RANDOM_ITEMS  = 1000;
    // The slowest compute used here covers at most 64 voxels, each pass reading
    // every empty voxel and its 14 neighbours in turn; the limit is generous.
    localparam int STALL_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;

    logic                  cmd_valid   = 1'b0;
    logic                  cmd_ready;
    logic [OPC_W-1:0]      opcode      = '0;
    logic [COORD_W-1:0]    coord_x     = '0;
    logic [COORD_W-1:0]    coord_y     = '0;
    logic [COORD_W-1:0]    coord_z     = '0;
    logic [VALUE_W-1:0]    voxel_value = '0;

    logic                  rsp_valid;
    logic                  rsp_ready   = 1'b0;
    logic [DIST_W-1:0]     distance;
    logic [PASS_W-1:0]     pass_count;

    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_W-1:0]    paddr       = '0;
    logic [PDATA_W-1:0]    pwdata      = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    quiet_cycles  = 0;

    // Register values as last written, used to aim loads and reads at the grid.
    logic [SIZE_W-1:0]     size_x_now    = SIZE_W'(GRID);
    logic [SIZE_W-1:0]     size_y_now    = SIZE_W'(GRID);
    logic [SIZE_W-1:0]     size_z_now    = SIZE_W'(GRID);
    logic [THRESH_W-1:0]   threshold_now = '0;

    // Voxels loaded since reset. A compute may only cover loaded voxels.
    bit                    loaded [CELLS];

    distance_field_3d_14_neighbour DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .voxel_value (voxel_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .distance    (distance),
        .pass_count  (pass_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    distance_field_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .voxel_value (voxel_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .distance    (distance),
        .pass_count  (pass_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #1 clk = ~clk;

    // The receiver drops ready at random with the stall rate of the current phase.
    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: a long stretch with no transaction on either channel means the
    // block has hung, so the run is stopped and reported as failed.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Effective extent of a size register: zero acts as one, oversize as the grid.
    function automatic int extent(logic [SIZE_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > GRID)
            return GRID;
        return int'(raw);
    endfunction

    function automatic bit in_grid(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z);
        return int'(x) < extent(size_x_now) && int'(y) < extent(size_y_now) &&
               int'(z) < extent(size_z_now);
    endfunction

    function automatic int cell_of(int x, int y, int z);
        return x + GRID * (y + GRID * z);
    endfunction

    // Mostly a coordinate inside the grid, sometimes anywhere in the field range
    // so that every coordinate bit toggles and out-of-grid commands occur.
    function automatic logic [COORD_W-1:0] pick_coord(int ext);
        if ($urandom_range(0, 99) < 70)
            return COORD_W'($urandom_range(0, ext - 1));
        return COORD_W'($urandom_range(0, GRID - 1));
    endfunction

    // Voxel values are biased toward empty so that distance fields form, with
    // some occupied seeds and some values spread over the whole range.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return VALUE_W'($urandom);
        if (r < 75 || threshold_now == '1)
            return VALUE_W'($urandom_range(0, int'(threshold_now)));
        return VALUE_W'($urandom_range(int'(threshold_now) + 1, 65535));
    endfunction

    // One register write: a setup phase, an access phase, then an idle gap with the
    // port deselected so that consecutive writes never collide on psel.
    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE_X:    size_x_now    = value[SIZE_W-1:0];
            REG_SIZE_Y:    size_y_now    = value[SIZE_W-1:0];
            REG_SIZE_Z:    size_z_now    = value[SIZE_W-1:0];
            REG_THRESHOLD: threshold_now = value[THRESH_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
    endtask

    // Writes all four registers. Half of the time the unused upper data bits
    // carry noise, which the block has to drop.
    task automatic set_grid(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                            logic [SIZE_W-1:0] sz, logic [THRESH_W-1:0] thr);
        logic [PDATA_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? PDATA_W'($urandom) : '0;
        write_reg(REG_SIZE_X, {junk[PDATA_W-1:SIZE_W], sx});
        write_reg(REG_SIZE_Y, {junk[PDATA_W-1:SIZE_W], sy});
        write_reg(REG_SIZE_Z, {junk[PDATA_W-1:SIZE_W], sz});
        write_reg(REG_THRESHOLD, {junk[PDATA_W-1:THRESH_W], thr});
    endtask

    // Small random grid of at most 64 voxels, which keeps every compute short.
    task automatic pick_small_grid();
        int sx, sy, sz;
        sx = $urandom_range(1, 6);
        sy = $urandom_range(1, 6);
        sz = $urandom_range(1, (64 / (sx * sy) > 1) ? 64 / (sx * sy) : 1);
        set_grid(SIZE_W'(sx), SIZE_W'(sy), SIZE_W'(sz), THRESH_W'($urandom));
    endtask

    // Presents one command transaction and returns at the edge that accepts it.
    // Valid is never lowered at that edge here; the next call decides.
    task automatic send_cmd(opcode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        opcode      <= op;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        voxel_value <= value;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (op == OP_LOAD && in_grid(x, y, z))
            loaded[cell_of(int'(x), int'(y), int'(z))] = 1'b1;
    endtask

    // Holds the command channel idle until every response has come back. The
    // checker's count is sampled at the falling edge, where it has settled.
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Loads every voxel of the grid that was never loaded, then runs a compute,
    // so that each voxel of the grid holds a distance afterward.
    task automatic fill_and_compute();
        for (int z = 0; z < extent(size_z_now); z++)
            for (int y = 0; y < extent(size_y_now); y++)
                for (int x = 0; x < extent(size_x_now); x++)
                    if (!loaded[cell_of(x, y, z)])
                        send_cmd(OP_LOAD, COORD_W'(x), COORD_W'(y), COORD_W'(z),
                                 pick_value());
        send_cmd(OP_COMPUTE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 VALUE_W'($urandom));
    endtask

    // Random traffic within one grid setting. Loads outside the grid and the
    // unused opcode do nothing in the block and are not counted.
    task automatic random_traffic(int items);
        int                 done, r;
        logic [COORD_W-1:0] x, y, z;
        done = 0;
        while (done < items)
        begin
            r = $urandom_range(0, 99);
            x = pick_coord(extent(size_x_now));
            y = pick_coord(extent(size_y_now));
            z = pick_coord(extent(size_z_now));
            if (r < 45)
            begin
                if (in_grid(x, y, z))
                    done++;
                send_cmd(OP_LOAD, x, y, z, pick_value());
            end
            else if (r < 88)
            begin
                send_cmd(OP_READ, x, y, z, VALUE_W'($urandom));
                done++;
            end
            else if (r < 92)
            begin
                fill_and_compute();
                done++;
            end
            else if (r < 98)
                send_cmd(OP_NONE, x, y, z, VALUE_W'($urandom));
            else
                drain();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Sizes of zero give a one-voxel grid with
        // maxd of one; the lone empty voxel sees only outside neighbours.
        set_grid('0, '0, '0, '0);
        send_cmd(OP_LOAD, '0, '0, '0, '0);
        send_cmd(OP_COMPUTE, '0, '0, '0, '0);
        send_cmd(OP_READ, '0, '0, '0, '1);
        // Coordinates outside the grid: the read answers zero, the load is dropped.
        send_cmd(OP_READ, '1, '1, '1, '0);
        send_cmd(OP_LOAD, '1, '0, '0, '1);
        send_cmd(OP_NONE, '1, '1, '1, '1);
        // The same voxel loaded occupied now gives distance zero.
        send_cmd(OP_LOAD, '0, '0, '0, '1);
        send_cmd(OP_COMPUTE, '1, '1, '1, '1);
        send_cmd(OP_READ, '0, '0, '0, '0);
        drain();

        // An oversize x extent acts as the full 32 voxels. With the top threshold
        // every voxel is empty, so every distance reaches maxd.
        set_grid('1, '0, '0, '1);
        send_cmd(OP_LOAD, '0, '0, '0, '1);
        fill_and_compute();
        send_cmd(OP_READ, COORD_W'(17), '0, '0, '0);
        drain();

        // Lowering the threshold must not reclassify voxels loaded before it.
        // One occupied voxel at the far end makes the field grow across the whole
        // line against the sweep direction, one voxel per sweep.
        write_reg(REG_THRESHOLD, PDATA_W'(100));
        send_cmd(OP_LOAD, '1, '0, '0, VALUE_W'(101));
        send_cmd(OP_LOAD, COORD_W'(30), '0, '0, VALUE_W'(100));
        send_cmd(OP_COMPUTE, '0, '0, '0, '0);
        send_cmd(OP_READ, '0, '0, '0, '0);
        send_cmd(OP_READ, '1, '0, '0, '0);
        send_cmd(OP_READ, COORD_W'(5), '1, '0, '0);
        drain();

        // Random part: one grid setting per phase, each with its own mix of
        // sender gaps and receiver stalls.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_grid(SIZE_W'(4), SIZE_W'(4), SIZE_W'(4), THRESH_W'($urandom));
                1:       set_grid('1, SIZE_W'(2), SIZE_W'(1), '0);
                2:       set_grid(SIZE_W'(1), SIZE_W'(33), '0, THRESH_W'($urandom));
                3:       set_grid('0, '0, SIZE_W'(40), '1);
                default: pick_small_grid();
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 66;
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct     = 14;
                end
            endcase
            fill_and_compute();
            random_traffic(RANDOM_ITEMS / PHASES);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
